// ===== rtl/core/spq_pkg.sv =====
package spq_pkg;

	// Operation codes carried on the func field.
	localparam logic [2:0] FN_QUERY = 3'd0;
	localparam logic [2:0] FN_PUSH  = 3'd1;
	localparam logic [2:0] FN_POP   = 3'd2;
	localparam logic [2:0] FN_LMIN  = 3'd3;
	localparam logic [2:0] FN_DUMP  = 3'd4;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_EX,
		S_PUT,
		S_REF_H,
		S_REF_T,
		S_REF_D,
		S_EMIT
	} seq_state_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

endpackage

// ===== rtl/core/spq_cmp.sv =====
module spq_cmp #(
	parameter int PRIO_WIDTH = 16
) (
	input  logic signed [PRIO_WIDTH-1:0] a,
	input  logic signed [PRIO_WIDTH-1:0] b,
	output spq_pkg::cmp_res_t             res
);
	import spq_pkg::*;

	// Signed priority comparison shared by the insert scan and the list scan.
	always_comb begin
		res.lt = (a < b);
		res.eq = (a == b);
	end

endmodule

// ===== rtl/core/spq_mem.sv =====
module spq_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int W     = 48
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/stable_priority_queue.sv =====
// Stable priority queue holding up to CAPACITY entries, each a data word with a signed
// priority, sorted from highest to lowest priority with equal priorities kept in arrival
// order. Requests choose query, push, pop, list-lowest or dump; every result carries the
// head, tail and occupancy as they stand after the request, and last marks the final
// result of a request. Entries live in a memory with one write port and one read port
// with registered read data, and one shared priority comparator is stepped over it by a
// small sequencer, so the block takes one request at a time. Query and error
// requests, as well as a pop that empties the queue, go straight to their result.
// A push compares entries from the tail toward the head, stopping at the first entry
// that stays in place, then places the new entry; a pop moves each remaining entry one
// slot toward the head. Both then reread the head and tail. List-lowest and dump scan
// from the head and emit each selected entry as its own result. Each compare step waits
// for one memory read, and a result that waits for the output holds the sequencer.
// While a result waits at the output register the next request is still taken. The
// memory needs no clearing after reset: only entries below the occupancy are ever read.
module stable_priority_queue #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32,
	parameter int PRIO_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [2:0]                   func,
	input  logic signed [DATA_WIDTH-1:0] item_value,
	input  logic signed [PRIO_WIDTH-1:0] item_priority,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic signed [DATA_WIDTH-1:0] out_value,
	output logic signed [PRIO_WIDTH-1:0] out_priority,
	output logic signed [DATA_WIDTH-1:0] head_value,
	output logic signed [PRIO_WIDTH-1:0] head_priority,
	output logic signed [DATA_WIDTH-1:0] tail_value,
	output logic signed [PRIO_WIDTH-1:0] tail_priority,
	output logic [$clog2(CAPACITY+1)-1:0] occupancy,
	output logic                         is_empty,
	output logic                         last
);
	import spq_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = DATA_WIDTH + PRIO_WIDTH;

	// Sequencer and control registers.
	seq_state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [2:0]    op_q, op_d;
	logic          last_q, last_d;
	logic          out_valid_q, out_valid_d;

	// Request and result holding registers.
	logic [DATA_WIDTH-1:0] new_val_q, new_val_d;
	logic [PRIO_WIDTH-1:0] new_prio_q, new_prio_d;
	logic [DATA_WIDTH-1:0] head_val_q, head_val_d, tail_val_q, tail_val_d;
	logic [PRIO_WIDTH-1:0] head_prio_q, head_prio_d, tail_prio_q, tail_prio_d;
	logic [1:0]            res_status_q, res_status_d;
	logic [DATA_WIDTH-1:0] res_val_q, res_val_d;
	logic [PRIO_WIDTH-1:0] res_prio_q, res_prio_d;

	// Output register.
	logic [1:0]            o_status_q;
	logic [DATA_WIDTH-1:0] o_val_q, o_hval_q, o_tval_q;
	logic [PRIO_WIDTH-1:0] o_prio_q, o_hprio_q, o_tprio_q;
	logic [CW-1:0]         o_count_q;
	logic                  o_empty_q, o_last_q;
	logic                  out_load;

	// Memory and comparator hookup.
	logic          mem_we;
	logic [IW-1:0] mem_waddr, mem_raddr;
	logic [EW-1:0] mem_wdata, mem_rdata;
	logic [DATA_WIDTH-1:0] rd_val;
	logic [PRIO_WIDTH-1:0] rd_prio;
	logic [PRIO_WIDTH-1:0] cmp_b;
	cmp_res_t              cmp_res;

	logic [IW-1:0] tail_idx;
	logic          at_tail;
	logic          q_empty;

	assign tail_idx = IW'(count_q - CW'(1));
	assign at_tail  = (CW'(idx_q) == (count_q - CW'(1)));
	assign q_empty  = (count_q == '0);
	assign rd_val   = mem_rdata[EW-1:PRIO_WIDTH];
	assign rd_prio  = mem_rdata[PRIO_WIDTH-1:0];

	// Insertion compares against the new priority, the list scan against the tail.
	assign cmp_b = (op_q == FN_PUSH) ? new_prio_q : tail_prio_q;

	spq_mem #(
		.DEPTH(CAPACITY),
		.AW   (IW),
		.W    (EW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	spq_cmp #(
		.PRIO_WIDTH(PRIO_WIDTH)
	) u_cmp (
		.a  (rd_prio),
		.b  (cmp_b),
		.res(cmp_res)
	);

	assign in_ready = (state_q == S_IDLE);

	// Read address: head and tail refresh use fixed slots, scans use the index.
	always_comb begin
		unique case (state_q)
			S_REF_H: mem_raddr = '0;
			S_REF_T: mem_raddr = tail_idx;
			default: mem_raddr = idx_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q        <= idx_d;
		op_q         <= op_d;
		last_q       <= last_d;
		new_val_q    <= new_val_d;
		new_prio_q   <= new_prio_d;
		head_val_q   <= head_val_d;
		head_prio_q  <= head_prio_d;
		tail_val_q   <= tail_val_d;
		tail_prio_q  <= tail_prio_d;
		res_status_q <= res_status_d;
		res_val_q    <= res_val_d;
		res_prio_q   <= res_prio_d;
		if (out_load) begin
			o_status_q <= res_status_q;
			o_val_q    <= res_val_q;
			o_prio_q   <= res_prio_q;
			o_hval_q   <= q_empty ? '0 : head_val_q;
			o_hprio_q  <= q_empty ? '0 : head_prio_q;
			o_tval_q   <= q_empty ? '0 : tail_val_q;
			o_tprio_q  <= q_empty ? '0 : tail_prio_q;
			o_count_q  <= count_q;
			o_empty_q  <= q_empty;
			o_last_q   <= last_q;
		end
	end

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		idx_d        = idx_q;
		op_d         = op_q;
		last_d       = last_q;
		new_val_d    = new_val_q;
		new_prio_d   = new_prio_q;
		head_val_d   = head_val_q;
		head_prio_d  = head_prio_q;
		tail_val_d   = tail_val_q;
		tail_prio_d  = tail_prio_q;
		res_status_d = res_status_q;
		res_val_d    = res_val_q;
		res_prio_d   = res_prio_q;
		mem_we       = 1'b0;
		mem_waddr    = idx_q;
		mem_wdata    = {new_val_q, new_prio_q};
		out_load     = 1'b0;
		out_valid_d  = out_valid_q && !out_ready;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_d         = func;
					last_d       = 1'b1;
					new_val_d    = item_value;
					new_prio_d   = item_priority;
					res_status_d = ST_OK;
					res_val_d    = '0;
					res_prio_d   = '0;
					state_d      = S_EMIT;
					unique case (func)
						FN_PUSH: begin
							if (count_q == CW'(CAPACITY)) begin
								res_status_d = ST_FULL;
							end else if (q_empty) begin
								idx_d   = '0;
								state_d = S_PUT;
							end else begin
								idx_d   = tail_idx;
								state_d = S_SCAN_RD;
							end
						end
						FN_POP, FN_LMIN, FN_DUMP: begin
							if (q_empty) begin
								res_status_d = ST_EMPTY;
							end else if (func == FN_POP) begin
								res_val_d  = head_val_q;
								res_prio_d = head_prio_q;
								if (count_q == CW'(1)) begin
									count_d = '0;
								end else begin
									idx_d   = IW'(1);
									state_d = S_SCAN_RD;
								end
							end else begin
								idx_d   = '0;
								state_d = S_SCAN_RD;
							end
						end
						default: begin
							op_d = FN_QUERY;
						end
					endcase
				end
			end
			S_SCAN_RD: begin
				state_d = S_SCAN_EX;
			end
			S_SCAN_EX: begin
				unique case (op_q)
					FN_PUSH: begin
						if (cmp_res.lt) begin
							// Lower priority entry moves one slot toward the tail.
							mem_we    = 1'b1;
							mem_waddr = IW'(idx_q + IW'(1));
							mem_wdata = mem_rdata;
							if (idx_q == '0) begin
								state_d = S_PUT;
							end else begin
								idx_d   = idx_q - IW'(1);
								state_d = S_SCAN_RD;
							end
						end else begin
							idx_d   = IW'(idx_q + IW'(1));
							state_d = S_PUT;
						end
					end
					FN_POP: begin
						mem_we    = 1'b1;
						mem_waddr = idx_q - IW'(1);
						mem_wdata = mem_rdata;
						if (at_tail) begin
							count_d = count_q - CW'(1);
							state_d = S_REF_H;
						end else begin
							idx_d   = IW'(idx_q + IW'(1));
							state_d = S_SCAN_RD;
						end
					end
					default: begin
						// List-lowest emits matching entries, dump emits all of them.
						if (op_q == FN_DUMP || cmp_res.eq) begin
							res_val_d  = rd_val;
							res_prio_d = rd_prio;
							last_d     = at_tail;
							state_d    = S_EMIT;
						end else begin
							idx_d   = IW'(idx_q + IW'(1));
							state_d = S_SCAN_RD;
						end
					end
				endcase
			end
			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = {new_val_q, new_prio_q};
				count_d   = count_q + CW'(1);
				state_d   = S_REF_H;
			end
			S_REF_H: begin
				state_d = S_REF_T;
			end
			S_REF_T: begin
				head_val_d  = rd_val;
				head_prio_d = rd_prio;
				state_d     = S_REF_D;
			end
			S_REF_D: begin
				tail_val_d  = rd_val;
				tail_prio_d = rd_prio;
				state_d     = S_EMIT;
			end
			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					out_load    = 1'b1;
					out_valid_d = 1'b1;
					if (last_q) begin
						state_d = S_IDLE;
					end else begin
						idx_d   = IW'(idx_q + IW'(1));
						state_d = S_SCAN_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign status        = o_status_q;
	assign out_value     = o_val_q;
	assign out_priority  = o_prio_q;
	assign head_value    = o_hval_q;
	assign head_priority = o_hprio_q;
	assign tail_value    = o_tval_q;
	assign tail_priority = o_tprio_q;
	assign occupancy     = o_count_q;
	assign is_empty      = o_empty_q;
	assign last          = o_last_q;

`ifndef SYNTHESIS
	// The fill count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// The fill count moves by at most one entry per step.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		(count_q == $past(count_q) + CW'(1) || count_q == $past(count_q) - CW'(1)))
		else $error("entry count jumped");

	// The memory is written only by the shift and placement steps.
	a_mem_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_PUT || state_q == S_SCAN_EX))
		else $error("memory written outside a shift or placement step");

	// A scan never reads past the last held entry.
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_RD) |-> (CW'(idx_q) < count_q))
		else $error("scan index beyond the held entries");

	// A presented result reports emptiness consistent with its occupancy.
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (o_empty_q == (o_count_q == '0)))
		else $error("empty flag disagrees with occupancy");
`endif

endmodule
